// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Property checked only outside reset.
`define ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ----- rtl/rrts_pkg.sv -----
// -----------------------------------------------------------------------------
// rrts_pkg
// Shared types, codes and constants of the round-robin thread scheduler.
// -----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

  localparam int DEFAULT_MAX_THREADS = 16;

  localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;
  localparam logic [19:0] QUANTUM_RESET = 20'd1000;
  localparam logic [2:0] NUM_PRIO_RESET = 3'd1;

  // Request kinds.
  localparam logic [2:0] KIND_SPAWN  = 3'd0;
  localparam logic [2:0] KIND_SETPRI = 3'd1;
  localparam logic [2:0] KIND_TERM   = 3'd2;
  localparam logic [2:0] KIND_BLOCK  = 3'd3;
  localparam logic [2:0] KIND_RESUME = 3'd4;
  localparam logic [2:0] KIND_QUERY  = 3'd5;
  localparam logic [2:0] KIND_TICK   = 3'd6;

  // Status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADID  = 2'd1;
  localparam logic [1:0] ST_NOFREE = 2'd2;
  localparam logic [1:0] ST_BADPRI = 2'd3;

  // Thread modes.
  localparam logic [1:0] MODE_RUNNING = 2'd0;
  localparam logic [1:0] MODE_BLOCKED = 2'd1;
  localparam logic [1:0] MODE_READY   = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_NUM_PRIO = 3'd0;
  localparam logic [2:0] REG_QUANT0   = 3'd1;
  localparam logic [2:0] REG_QUANT1   = 3'd2;
  localparam logic [2:0] REG_QUANT2   = 3'd3;
  localparam logic [2:0] REG_QUANT3   = 3'd4;

  typedef struct packed {
    logic [2:0]       num_priorities;
    logic [3:0][19:0] quantum;
  } cfg_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] tid;
    logic [2:0] prio;
    logic       in_range;
    logic       prio_ok;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  new_thread_id;
    logic [3:0]  running_thread;
    logic        switched;
    logic [30:0] total_slices;
    logic [30:0] thread_slices;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/rrts_front.sv -----
// -----------------------------------------------------------------------------
// rrts_front
// Accepts requests, classifies their ids and priorities, and holds them in a
// two-entry queue for the back end.
// -----------------------------------------------------------------------------
`default_nettype none

module rrts_front import rrts_pkg::*; #(
  parameter int MAX_THREADS = DEFAULT_MAX_THREADS
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [2:0] kind,
  input  wire logic [7:0] thread_id,
  input  wire logic [2:0] priority_req,
  input  wire cfg_t       cfg,
  output logic            cmd_valid,
  output cmd_t            cmd_head,
  input  wire logic       cmd_pop
);

  cmd_t       cmd_mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  cmd_t       cls;
  logic       do_push;
  logic       do_pop;

  // Classify the incoming request.
  always_comb begin
    cls.kind     = kind;
    cls.tid      = thread_id;
    cls.prio     = priority_req;
    cls.in_range = {1'b0, thread_id} < 9'(MAX_THREADS);
    cls.prio_ok  = (priority_req < cfg.num_priorities) && (priority_req < 3'd4);
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd_head  = cmd_mem[rp];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  // Request queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      cmd_mem[wp] <= cls;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rrts_back.sv -----
// -----------------------------------------------------------------------------
// rrts_back
// Carries out one request at a time: free id scan, ready queue walk, dispatch,
// and the final count lookup; results go to a two-entry queue.
// -----------------------------------------------------------------------------
`default_nettype none

module rrts_back import rrts_pkg::*; #(
  parameter int MAX_THREADS = DEFAULT_MAX_THREADS
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd_head,
  output logic      cmd_pop,
  output logic      empty,
  input  wire logic pop,
  output res_t      res
);

  localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int CW = $clog2(MAX_THREADS + 1);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_FIND     = 10'b00_0000_0010,
    S_EXEC     = 10'b00_0000_0100,
    S_RM_RD    = 10'b00_0000_1000,
    S_RM_CMP   = 10'b00_0001_0000,
    S_DISP_RD  = 10'b00_0010_0000,
    S_DISP_RD2 = 10'b00_0100_0000,
    S_DISP_WR  = 10'b00_1000_0000,
    S_SLICE    = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } state_t;

  state_t state;

  // Scheduler state.
  logic [MAX_THREADS-1:0] exists;
  logic [CW-1:0]          ready_count;
  logic [TW-1:0]          head;
  logic [TW-1:0]          current;
  logic [19:0]            slice_rem;
  logic [30:0]            total;

  // Per-request working registers.
  cmd_t          cur;
  logic [CW-1:0] scan;
  logic [CW-1:0] wcnt;
  logic [TW-1:0] dt;
  logic          rm_disp;
  logic          term;
  logic [1:0]    st;
  logic [TW-1:0] nid;
  logic          sw;

  // Memories.
  logic [1:0]    mode_mem  [MAX_THREADS];
  logic [19:0]   quant_mem [MAX_THREADS];
  logic [30:0]   disp_mem  [MAX_THREADS];
  logic [TW-1:0] fifo_mem  [MAX_THREADS];
  logic [1:0]    mode_q;
  logic [19:0]   quant_q;
  logic [30:0]   disp_q;
  logic [TW-1:0] fifo_q;

  logic          mode_we;
  logic [TW-1:0] mode_wa;
  logic [1:0]    mode_wd;
  logic [TW-1:0] mode_ra;
  logic          quant_we;
  logic [TW-1:0] quant_wa;
  logic [TW-1:0] quant_ra;
  logic          disp_we;
  logic [TW-1:0] disp_wa;
  logic [30:0]   disp_wd;
  logic [TW-1:0] disp_ra;
  logic          fifo_we;
  logic [TW-1:0] fifo_wa;
  logic [TW-1:0] fifo_wd;
  logic [TW-1:0] fifo_ra;

  // Result queue.
  res_t       res_mem [2];
  logic       rwp;
  logic       rrp;
  logic [1:0] rcount;
  logic       res_push;
  res_t       res_new;

  logic [TW-1:0] t_idx;
  logic [TW-1:0] scan_t;
  logic          id_ok;
  logic          q_space;
  logic [TW-1:0] tail;
  logic [19:0]   quant_sel;

  // Index arithmetic on the circular ready queue.
  function automatic logic [TW-1:0] wrap_add(input logic [TW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + {1'b0, b};
    if (s >= (CW+1)'(MAX_THREADS)) begin
      s = s - (CW+1)'(MAX_THREADS);
    end
    return s[TW-1:0];
  endfunction

  assign t_idx     = cur.tid[TW-1:0];
  assign scan_t    = scan[TW-1:0];
  assign id_ok     = cur.in_range && exists[t_idx];
  assign q_space   = ready_count < CW'(MAX_THREADS);
  assign tail      = wrap_add(head, ready_count);
  assign quant_sel = cfg.quantum[cur.prio[1:0]];
  assign cmd_pop   = (state == S_IDLE) && cmd_valid && (rcount != 2'd2);
  assign res_push  = (state == S_DONE);

  // Memory port control.
  always_comb begin
    mode_we  = 1'b0;
    mode_wa  = t_idx;
    mode_wd  = MODE_BLOCKED;
    mode_ra  = (cmd_head.kind == KIND_TICK) ? current : cmd_head.tid[TW-1:0];
    quant_we = 1'b0;
    quant_wa = t_idx;
    quant_ra = fifo_q;
    disp_we  = 1'b0;
    disp_wa  = dt;
    disp_wd  = '0;
    disp_ra  = fifo_q;
    fifo_we  = 1'b0;
    fifo_wa  = tail;
    fifo_wd  = t_idx;
    fifo_ra  = head;
    case (state)
      S_FIND: begin
        if (!exists[scan_t] && cur.prio_ok) begin
          quant_we = 1'b1;
          quant_wa = scan_t;
          disp_we  = 1'b1;
          disp_wa  = scan_t;
          disp_wd  = '0;
          mode_we  = 1'b1;
          mode_wa  = scan_t;
          mode_wd  = MODE_READY;
          fifo_we  = q_space;
          fifo_wd  = scan_t;
        end
      end
      S_EXEC: begin
        case (cur.kind)
          KIND_SETPRI: begin
            quant_we = id_ok && cur.prio_ok;
          end
          KIND_BLOCK: begin
            if (cur.tid != 8'd0 && id_ok) begin
              mode_we = (t_idx == current) || (mode_q != MODE_BLOCKED);
            end
          end
          KIND_RESUME: begin
            if (id_ok && mode_q == MODE_BLOCKED) begin
              mode_we = 1'b1;
              mode_wd = MODE_READY;
              fifo_we = q_space;
            end
          end
          KIND_TICK: begin
            if (exists[0] && slice_rem <= 20'd1 && exists[current]
                && mode_q == MODE_RUNNING) begin
              mode_we = 1'b1;
              mode_wa = current;
              mode_wd = MODE_READY;
              fifo_we = q_space;
              fifo_wd = current;
            end
          end
          default: begin
          end
        endcase
      end
      S_RM_RD: begin
        fifo_ra = wrap_add(head, scan);
      end
      S_RM_CMP: begin
        fifo_we = (fifo_q != t_idx);
        fifo_wa = wrap_add(head, wcnt);
        fifo_wd = fifo_q;
      end
      S_DISP_WR: begin
        disp_we = 1'b1;
        disp_wa = dt;
        disp_wd = (disp_q < SAT31) ? disp_q + 31'd1 : disp_q;
        mode_we = 1'b1;
        mode_wa = dt;
        mode_wd = MODE_RUNNING;
      end
      S_SLICE: begin
        disp_ra = t_idx;
      end
      default: begin
      end
    endcase
  end

  // Memory arrays with registered reads.
  always_ff @(posedge clk) begin
    if (mode_we) begin
      mode_mem[mode_wa] <= mode_wd;
    end
    mode_q <= mode_mem[mode_ra];
  end

  always_ff @(posedge clk) begin
    if (quant_we) begin
      quant_mem[quant_wa] <= quant_sel;
    end
    quant_q <= quant_mem[quant_ra];
  end

  always_ff @(posedge clk) begin
    if (disp_we) begin
      disp_mem[disp_wa] <= disp_wd;
    end
    disp_q <= disp_mem[disp_ra];
  end

  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[fifo_wa] <= fifo_wd;
    end
    fifo_q <= fifo_mem[fifo_ra];
  end

  // Request sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      exists      <= '0;
      ready_count <= '0;
      head        <= '0;
      current     <= '0;
      slice_rem   <= '0;
      total       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            cur   <= cmd_head;
            st    <= ST_OK;
            nid   <= '0;
            sw    <= 1'b0;
            scan  <= '0;
            state <= (cmd_head.kind == KIND_SPAWN) ? S_FIND : S_EXEC;
          end
        end
        S_FIND: begin
          if (!exists[scan_t]) begin
            if (!cur.prio_ok) begin
              st    <= ST_BADPRI;
              state <= S_SLICE;
            end else begin
              exists[scan_t] <= 1'b1;
              if (q_space) begin
                ready_count <= ready_count + CW'(1);
              end
              nid   <= scan_t;
              term  <= 1'b0;
              state <= (scan_t == '0) ? S_DISP_RD : S_SLICE;
            end
          end else if (scan == CW'(MAX_THREADS - 1)) begin
            st    <= ST_NOFREE;
            state <= S_SLICE;
          end else begin
            scan <= scan + CW'(1);
          end
        end
        S_EXEC: begin
          state <= S_SLICE;
          scan  <= '0;
          wcnt  <= '0;
          case (cur.kind)
            KIND_SETPRI: begin
              if (!id_ok) begin
                st <= ST_BADID;
              end else if (!cur.prio_ok) begin
                st <= ST_BADPRI;
              end
            end
            KIND_TERM: begin
              if (!id_ok) begin
                st <= ST_BADID;
              end else if (t_idx == '0) begin
                // Terminating the first thread returns to the reset state.
                exists      <= '0;
                ready_count <= '0;
                head        <= '0;
                current     <= '0;
                slice_rem   <= '0;
                total       <= '0;
              end else begin
                exists[t_idx] <= 1'b0;
                rm_disp       <= (t_idx == current);
                term          <= 1'b1;
                state         <= S_RM_RD;
              end
            end
            KIND_BLOCK: begin
              if (cur.tid == 8'd0 || !id_ok) begin
                st <= ST_BADID;
              end else if (t_idx == current) begin
                rm_disp <= 1'b1;
                term    <= 1'b0;
                state   <= S_RM_RD;
              end else if (mode_q != MODE_BLOCKED) begin
                rm_disp <= 1'b0;
                state   <= S_RM_RD;
              end
            end
            KIND_RESUME: begin
              if (!id_ok) begin
                st <= ST_BADID;
              end else if (mode_q == MODE_BLOCKED && q_space) begin
                ready_count <= ready_count + CW'(1);
              end
            end
            KIND_QUERY: begin
              if (!id_ok) begin
                st <= ST_BADID;
              end
            end
            KIND_TICK: begin
              if (exists[0]) begin
                if (slice_rem > 20'd1) begin
                  slice_rem <= slice_rem - 20'd1;
                end else begin
                  slice_rem <= '0;
                  if (exists[current] && mode_q == MODE_RUNNING && q_space) begin
                    ready_count <= ready_count + CW'(1);
                  end
                  term  <= 1'b0;
                  state <= S_DISP_RD;
                end
              end
            end
            default: begin
            end
          endcase
        end
        // Walk the queue and compact out the removed thread.
        S_RM_RD: begin
          if (scan == ready_count) begin
            ready_count <= wcnt;
            state       <= rm_disp ? S_DISP_RD : S_SLICE;
          end else begin
            state <= S_RM_CMP;
          end
        end
        S_RM_CMP: begin
          if (fifo_q != t_idx) begin
            wcnt <= wcnt + CW'(1);
          end
          scan  <= scan + CW'(1);
          state <= S_RM_RD;
        end
        // Dispatch the head of the ready queue.
        S_DISP_RD: begin
          if (ready_count == '0) begin
            if (term) begin
              current   <= '0;
              slice_rem <= '0;
            end
            state <= S_SLICE;
          end else begin
            state <= S_DISP_RD2;
          end
        end
        S_DISP_RD2: begin
          dt    <= fifo_q;
          state <= S_DISP_WR;
        end
        S_DISP_WR: begin
          current     <= dt;
          slice_rem   <= quant_q;
          head        <= wrap_add(head, CW'(1));
          ready_count <= ready_count - CW'(1);
          sw          <= 1'b1;
          if (total < SAT31) begin
            total <= total + 31'd1;
          end
          state <= S_SLICE;
        end
        S_SLICE: begin
          state <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Assemble the result.
  always_comb begin
    res_new.status         = st;
    res_new.new_thread_id  = 4'(nid);
    res_new.running_thread = 4'(current);
    res_new.switched       = sw;
    res_new.total_slices   = total;
    res_new.thread_slices  = id_ok ? disp_q : '0;
  end

  assign empty = (rcount == 2'd0);
  assign res   = res_mem[rrp];

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_mem[rwp] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rwp    <= 1'b0;
      rrp    <= 1'b0;
      rcount <= 2'd0;
    end else begin
      if (res_push) begin
        rwp <= ~rwp;
      end
      if (pop && !empty) begin
        rrp <= ~rrp;
      end
      rcount <= rcount + {1'b0, res_push} - {1'b0, pop && !empty};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/round_robin_thread_scheduler_core.sv -----
// The back end carries out one request at a time: a spawn scans for a free id, block
// and terminate walk the ready queue to compact it, and a dispatch reads the queue head
// and writes the thread's mode and count; two-entry request and result queues decouple
// the ports. Reset clears all control state.
// -----------------------------------------------------------------------------
// round_robin_thread_scheduler_core
// Round-robin thread scheduler with per-priority time slices: configuration
// registers, request front end and scheduling back end.
// -----------------------------------------------------------------------------
`default_nettype none

module round_robin_thread_scheduler_core import rrts_pkg::*; #(
  parameter int MAX_THREADS = DEFAULT_MAX_THREADS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  kind,
  input  wire logic [7:0]  thread_id,
  input  wire logic [2:0]  priority_req,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       status,
  output logic [3:0]       new_thread_id,
  output logic [3:0]       running_thread,
  output logic             switched,
  output logic [30:0]      total_slices,
  output logic [30:0]      thread_slices,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [19:0] cfg_data
);

  cfg_t cfg;
  logic cmd_valid;
  cmd_t cmd_head;
  logic cmd_pop;
  res_t res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_priorities <= NUM_PRIO_RESET;
      cfg.quantum        <= {4{QUANTUM_RESET}};
    end else if (cfg_write) begin
      case (cfg_index)
        REG_NUM_PRIO: cfg.num_priorities <= cfg_data[2:0];
        REG_QUANT0:   cfg.quantum[0] <= cfg_data;
        REG_QUANT1:   cfg.quantum[1] <= cfg_data;
        REG_QUANT2:   cfg.quantum[2] <= cfg_data;
        REG_QUANT3:   cfg.quantum[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rrts_front #(.MAX_THREADS(MAX_THREADS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .kind         (kind),
    .thread_id    (thread_id),
    .priority_req (priority_req),
    .cfg          (cfg),
    .cmd_valid    (cmd_valid),
    .cmd_head     (cmd_head),
    .cmd_pop      (cmd_pop)
  );

  rrts_back #(.MAX_THREADS(MAX_THREADS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

  assign status         = res.status;
  assign new_thread_id  = res.new_thread_id;
  assign running_thread = res.running_thread;
  assign switched       = res.switched;
  assign total_slices   = res.total_slices;
  assign thread_slices  = res.thread_slices;

endmodule

`default_nettype wire

// ----- rtl/rrts_checker.sv -----
// -----------------------------------------------------------------------------
// rrts_checker
// Port-level checks of the scheduler's result queue.
// -----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rrts_checker import rrts_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [1:0]  status,
  input wire logic [3:0]  new_thread_id,
  input wire logic        switched,
  input wire logic [30:0] total_slices
);

  // The result queue is empty after reset.
  `ASSERT_CLK(a_empty_after_rst, clk, rst |=> empty, "result queue not empty after reset")

  // A dispatch always shows in the running total.
  `ASSERT_RST(a_switch_total, clk, rst, (!empty && switched) |-> (total_slices != 31'd0), "dispatch with zero total")

  // A rejected request neither spawns nor dispatches.
  `ASSERT_RST(a_err_quiet, clk, rst, (!empty && status != ST_OK) |-> (new_thread_id == 4'd0 && !switched), "failed request has side effects")

  // A waiting result holds until it is taken.
  `ASSERT_RST(a_hold, clk, rst, (!empty && !pop) |=> (!empty && $stable(status) && $stable(total_slices)), "waiting result changed")

endmodule

bind round_robin_thread_scheduler_core rrts_checker u_rrts_checker (
  .clk           (clk),
  .rst           (rst),
  .empty         (empty),
  .pop           (pop),
  .status        (status),
  .new_thread_id (new_thread_id),
  .switched      (switched),
  .total_slices  (total_slices)
);

`default_nettype wire

// ----- sim/tb_round_robin_thread_scheduler_core.sv -----
// -----------------------------------------------------------------------------
// Round-robin thread scheduler testbench
// Sends scheduler requests through the push/full port and checks every result
// against a predictor of the scheduler kept in the testbench. A short table of
// directed requests is followed by random requests in several phases, each
// with its own set of priority count and quantum registers.
// -----------------------------------------------------------------------------
`default_nettype none

module tb_round_robin_thread_scheduler_core;
  import rrts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTHR = 16;
  localparam logic [2:0] KIND_NOP = 3'd7;
  localparam int RAND_PER_PHASE = 90;
  localparam int SETTLE_CYCLES = 80;
  localparam int STALL_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 3000;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [2:0]  kind;
  logic [7:0]  thread_id;
  logic [2:0]  priority_req;
  logic        empty;
  logic        pop;
  logic [1:0]  status;
  logic [3:0]  new_thread_id;
  logic [3:0]  running_thread;
  logic        switched;
  logic [30:0] total_slices;
  logic [30:0] thread_slices;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [19:0] cfg_data;

  round_robin_thread_scheduler_core dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .kind(kind),
    .thread_id(thread_id), .priority_req(priority_req), .empty(empty),
    .pop(pop), .status(status), .new_thread_id(new_thread_id),
    .running_thread(running_thread), .switched(switched),
    .total_slices(total_slices), .thread_slices(thread_slices),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Scheduler mirror: configuration and thread state.
  logic [2:0]  sched_nprio;
  logic [19:0] sched_quantum [4];
  logic        thr_exists [NTHR];
  logic [1:0]  thr_mode [NTHR];
  logic [19:0] thr_quantum [NTHR];
  logic [30:0] thr_dispatches [NTHR];
  logic [3:0]  ready_q [$];
  logic [3:0]  cur_thread;
  logic [19:0] slice_left;
  logic [30:0] dispatch_count;

  res_t sched_results [$];
  int   mismatches;
  int   results_seen;

  // Directed request table; typed rows carry their own expected result.
  typedef struct {
    logic [2:0] k;
    logic [7:0] tid;
    logic [2:0] prio;
    bit         typed;
    res_t       res;
  } req_row_t;

  localparam res_t RES_ZERO = '0;

  req_row_t directed [] = '{
    '{KIND_TICK,   8'd0,   3'd0, 1, RES_ZERO},
    '{KIND_QUERY,  8'd0,   3'd0, 1, '{ST_BADID, 4'd0, 4'd0, 1'b0, 31'd0, 31'd0}},
    '{KIND_SPAWN,  8'd0,   3'd0, 1, '{ST_OK, 4'd0, 4'd0, 1'b1, 31'd1, 31'd1}},
    '{KIND_SPAWN,  8'd255, 3'd7, 1, '{ST_BADPRI, 4'd0, 4'd0, 1'b0, 31'd1, 31'd0}},
    '{KIND_SPAWN,  8'd1,   3'd1, 0, RES_ZERO},
    '{KIND_SPAWN,  8'd2,   3'd3, 0, RES_ZERO},
    '{KIND_SETPRI, 8'd1,   3'd2, 0, RES_ZERO},
    '{KIND_SETPRI, 8'd200, 3'd0, 1, '{ST_BADID, 4'd0, 4'd0, 1'b0, 31'd1, 31'd0}},
    '{KIND_SETPRI, 8'd1,   3'd4, 0, RES_ZERO},
    '{KIND_BLOCK,  8'd0,   3'd0, 1, '{ST_BADID, 4'd0, 4'd0, 1'b0, 31'd1, 31'd1}},
    '{KIND_TICK,   8'd1,   3'd0, 0, RES_ZERO},
    '{KIND_TICK,   8'd2,   3'd0, 0, RES_ZERO},
    '{KIND_TICK,   8'd0,   3'd0, 0, RES_ZERO},
    '{KIND_BLOCK,  8'd1,   3'd0, 0, RES_ZERO},
    '{KIND_RESUME, 8'd1,   3'd0, 0, RES_ZERO},
    '{KIND_RESUME, 8'd2,   3'd0, 0, RES_ZERO},
    '{KIND_BLOCK,  8'd2,   3'd0, 0, RES_ZERO},
    '{KIND_BLOCK,  8'd2,   3'd0, 0, RES_ZERO},
    '{KIND_RESUME, 8'd2,   3'd0, 0, RES_ZERO},
    '{KIND_TERM,   8'd2,   3'd0, 0, RES_ZERO},
    '{KIND_NOP,    8'd128, 3'd5, 0, RES_ZERO},
    '{KIND_QUERY,  8'd255, 3'd0, 0, RES_ZERO},
    '{KIND_TERM,   8'd0,   3'd0, 1, RES_ZERO},
    '{KIND_SPAWN,  8'd0,   3'd7, 0, RES_ZERO}
  };

  // Register settings per phase: priority count, then quanta of levels 0..3.
  logic [19:0] phase_cfg [7][5] = '{
    '{20'd4, 20'd1,      20'd2, 20'd3, 20'd1},
    '{20'd1, 20'd1,      20'd1, 20'd1, 20'd1},
    '{20'd4, 20'd999999, 20'd1, 20'd2, 20'd3},
    '{20'd7, 20'd3,      20'd0, 20'd5, 20'hFFFFF},
    '{20'd0, 20'd2,      20'd2, 20'd2, 20'd2},
    '{20'd3, 20'd4,      20'd1, 20'd2, 20'd5},
    '{20'd4, 20'd1,      20'd3, 20'd2, 20'd999999}
  };

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Return all thread state to its reset values.
  function automatic void sched_clear();
    for (int i = 0; i < NTHR; i++) begin
      thr_exists[i] = 1'b0;
      thr_mode[i] = MODE_RUNNING;
      thr_quantum[i] = '0;
      thr_dispatches[i] = '0;
    end
    ready_q.delete();
    cur_thread = '0;
    slice_left = '0;
    dispatch_count = '0;
  endfunction

  function automatic bit prio_valid(logic [2:0] p);
    return (p < sched_nprio) && (p < 3'd4);
  endfunction

  function automatic bit id_valid(logic [7:0] t);
    return (t < NTHR) && thr_exists[t[3:0]];
  endfunction

  // Move the head of the ready queue onto the processor.
  function automatic logic sched_dispatch();
    logic [3:0] t;
    if (ready_q.size() == 0) return 1'b0;
    t = ready_q[0];
    ready_q.delete(0);
    cur_thread = t;
    if (dispatch_count != SAT31) dispatch_count++;
    if (thr_dispatches[t] != SAT31) thr_dispatches[t]++;
    thr_mode[t] = MODE_RUNNING;
    slice_left = thr_quantum[t];
    return 1'b1;
  endfunction

  function automatic void ready_drop(logic [3:0] t);
    for (int i = ready_q.size() - 1; i >= 0; i--)
      if (ready_q[i] == t) ready_q.delete(i);
  endfunction

  // Apply one request to the mirror and return the result it produces.
  function automatic res_t sched_apply(logic [2:0] k, logic [7:0] tid, logic [2:0] p);
    res_t r;
    logic [3:0] t;
    int freeid;
    r = '0;
    t = tid[3:0];
    case (k)
      KIND_SPAWN: begin
        freeid = NTHR;
        for (int i = NTHR - 1; i >= 0; i--)
          if (!thr_exists[i]) freeid = i;
        if (freeid == NTHR) r.status = ST_NOFREE;
        else if (!prio_valid(p)) r.status = ST_BADPRI;
        else begin
          thr_exists[freeid] = 1'b1;
          thr_quantum[freeid] = sched_quantum[p[1:0]];
          thr_dispatches[freeid] = '0;
          thr_mode[freeid] = MODE_READY;
          if (ready_q.size() < NTHR) ready_q.insert(ready_q.size(), freeid[3:0]);
          r.new_thread_id = freeid[3:0];
          if (freeid == 0) r.switched = sched_dispatch();
        end
      end
      KIND_SETPRI: begin
        if (!id_valid(tid)) r.status = ST_BADID;
        else if (!prio_valid(p)) r.status = ST_BADPRI;
        else thr_quantum[t] = sched_quantum[p[1:0]];
      end
      KIND_TERM: begin
        if (!id_valid(tid)) r.status = ST_BADID;
        else if (t == 0) sched_clear();
        else begin
          ready_drop(t);
          thr_exists[t] = 1'b0;
          if (t == cur_thread) begin
            r.switched = sched_dispatch();
            if (!r.switched) begin
              cur_thread = '0;
              slice_left = '0;
            end
          end
        end
      end
      KIND_BLOCK: begin
        if (tid == 0 || !id_valid(tid)) r.status = ST_BADID;
        else if (t == cur_thread) begin
          thr_mode[t] = MODE_BLOCKED;
          ready_drop(t);
          r.switched = sched_dispatch();
        end else if (thr_mode[t] != MODE_BLOCKED) begin
          thr_mode[t] = MODE_BLOCKED;
          ready_drop(t);
        end
      end
      KIND_RESUME: begin
        if (!id_valid(tid)) r.status = ST_BADID;
        else if (thr_mode[t] == MODE_BLOCKED) begin
          thr_mode[t] = MODE_READY;
          if (ready_q.size() < NTHR) ready_q.insert(ready_q.size(), t);
        end
      end
      KIND_QUERY: begin
        if (!id_valid(tid)) r.status = ST_BADID;
      end
      KIND_TICK: begin
        if (thr_exists[0]) begin
          if (slice_left > 1) slice_left--;
          else begin
            slice_left = '0;
            if (thr_exists[cur_thread] && thr_mode[cur_thread] == MODE_RUNNING) begin
              thr_mode[cur_thread] = MODE_READY;
              if (ready_q.size() < NTHR) ready_q.insert(ready_q.size(), cur_thread);
            end
            r.switched = sched_dispatch();
          end
        end
      end
      default: ;
    endcase
    r.running_thread = cur_thread;
    r.total_slices = dispatch_count;
    if (id_valid(tid)) r.thread_slices = thr_dispatches[t];
    return r;
  endfunction

  // Idle length: mostly none, sometimes short, rarely long.
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Offer one request and record its expected result once accepted.
  task automatic send_request(logic [2:0] k, logic [7:0] tid, logic [2:0] p,
                              bit typed, res_t typed_res);
    int gap;
    res_t predicted;
    gap = idle_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    kind <= k;
    thread_id <= tid;
    priority_req <= p;
    do @(posedge clk); while (full);
    predicted = sched_apply(k, tid, p);
    sched_results.insert(sched_results.size(), typed ? typed_res : predicted);
  endtask

  // Write all registers of one phase while the scheduler is idle.
  task automatic load_phase(int ph);
    push <= 1'b0;
    while (sched_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = 0; i < 5; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data <= phase_cfg[ph][i];
      @(posedge clk);
      if (i == 0) sched_nprio = phase_cfg[ph][i][2:0];
      else sched_quantum[i - 1] = phase_cfg[ph][i];
    end
    // An index past the last register must be ignored.
    cfg_index <= 3'($urandom_range(7, 5));
    cfg_data <= 20'($urandom);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Random request with a mix weighted toward spawns and ticks.
  task automatic send_random();
    int roll;
    logic [2:0] k;
    logic [7:0] tid;
    logic [2:0] p;
    roll = $urandom_range(99);
    if (roll < 20) k = KIND_SPAWN;
    else if (roll < 30) k = KIND_SETPRI;
    else if (roll < 38) k = KIND_TERM;
    else if (roll < 48) k = KIND_BLOCK;
    else if (roll < 60) k = KIND_RESUME;
    else if (roll < 67) k = KIND_QUERY;
    else if (roll < 97) k = KIND_TICK;
    else k = KIND_NOP;
    tid = ($urandom_range(99) < 85) ? 8'($urandom_range(NTHR - 1)) : 8'($urandom);
    // Keep full resets rare so the thread table gets a chance to fill up.
    if (k == KIND_TERM && tid == 0 && $urandom_range(3) != 0)
      tid = 8'($urandom_range(NTHR - 1, 1));
    p = ($urandom_range(99) < 80) ? 3'($urandom_range(3)) : 3'($urandom);
    send_request(k, tid, p, 1'b0, RES_ZERO);
  endtask

  // Stimulus.
  initial begin
    rst = 1'b1;
    push = 1'b0;
    kind = '0;
    thread_id = '0;
    priority_req = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sched_nprio = NUM_PRIO_RESET;
    for (int i = 0; i < 4; i++) sched_quantum[i] = QUANTUM_RESET;
    sched_clear();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    load_phase(0);
    foreach (directed[i])
      send_request(directed[i].k, directed[i].tid, directed[i].prio,
                   directed[i].typed, directed[i].res);

    for (int ph = 1; ph < 7; ph++) begin
      load_phase(ph);
      repeat (RAND_PER_PHASE) send_random();
    end
    push <= 1'b0;

    while (sched_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Result side: random pop with one long hold-off to back up the block.
  initial begin
    res_t got;
    res_t want;
    pop = 1'b0;
    mismatches = 0;
    results_seen = 0;
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        got = '{status, new_thread_id, running_thread, switched,
                total_slices, thread_slices};
        results_seen++;
        if (sched_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: result with no request pending: %p", got);
        end else begin
          want = sched_results[0];
          sched_results.delete(0);
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result %0d expected %p got %p", results_seen, want, got);
          end
        end
        if (results_seen == 150) begin
          pop <= 1'b0;
          repeat (STALL_CYCLES) @(posedge clk);
        end
      end
      if (!rst) pop <= ($urandom_range(99) < 75) || ($urandom_range(99) < 50 && results_seen > 300);
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || rst) quiet = 0;
      else quiet++;
      if (quiet == WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
